### rtl/gbc_pkg.sv
// gbc_pkg: shared types and fixed constants of the gyro bias calibrator.
// No dependencies; every other file refers to it by scoped names.
package gbc_pkg;

   // fixed widths
   localparam int SUM_WIDTH       = 32;
   localparam int DIVIDEND_WIDTH  = SUM_WIDTH + 1;
   localparam int BIAS_WIDTH      = 16;
   localparam int REQ_WIDTH       = 16;
   localparam int ACC_TOL_WIDTH   = 15;
   localparam int GYRO_TOL_WIDTH  = 15;
   localparam int TOL_OP_WIDTH    = 16;
   localparam int TOL_SQ_WIDTH    = 2 * TOL_OP_WIDTH;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 16;

   // register reset values
   localparam logic [REQ_WIDTH-1:0]      REQUIRED_RESET  = 16'd1000;
   localparam logic [ACC_TOL_WIDTH-1:0]  ACC_TOL_RESET   = 15'd410;
   localparam logic [GYRO_TOL_WIDTH-1:0] GYRO_TOL_RESET  = 15'd100;

   localparam logic signed [BIAS_WIDTH-1:0] BIAS_MAX = 16'sh7FFF;
   localparam logic signed [BIAS_WIDTH-1:0] BIAS_MIN = 16'sh8000;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_REQUIRED_SAMPLES = 2'd0,
      CSR_ACCEL_TOLERANCE  = 2'd1,
      CSR_GYRO_TOLERANCE   = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQ0,
      ST_SQ1,
      ST_SQ2,
      ST_EVAL,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_RESULT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic     in_load;
      logic     sq_en;
      axis_type sq_axis;
      logic     eval;
      logic     div_start;
      axis_type div_axis;
      logic     bias_load;
      logic     set_cal;
      logic     out_load;
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic complete;
      logic div_done;
   } dp_status_type;

endpackage

### rtl/gbc_div.sv
// gbc_div: restoring unsigned divider, one quotient bit per cycle.
// Uses gbc_pkg for the dividend width.
module gbc_div #(
   parameter int DIVISOR_WIDTH = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [gbc_pkg::DIVIDEND_WIDTH-1:0]   dividend,
   input  logic [DIVISOR_WIDTH-1:0]             divisor,
   output logic                                 done,
   output logic [gbc_pkg::DIVIDEND_WIDTH-1:0]   quotient
);

   localparam int DW   = gbc_pkg::DIVIDEND_WIDTH;
   localparam int CNTW = $clog2(DW + 1);

   logic [DW-1:0]            quo_ff, quo_in;
   logic [DIVISOR_WIDTH-1:0] rem_ff, rem_in;
   logic [CNTW-1:0]          cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;

   logic [DIVISOR_WIDTH:0]   rem_shift;
   logic [DIVISOR_WIDTH:0]   rem_sub;
   logic                     ge;

   assign rem_shift = {rem_ff, quo_ff[DW-1]};
   assign rem_sub   = rem_shift - {1'b0, divisor};
   assign ge        = rem_shift >= {1'b0, divisor};

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = CNTW'(DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so the low bits suffice
         rem_in = ge ? rem_sub[DIVISOR_WIDTH-1:0] : rem_shift[DIVISOR_WIDTH-1:0];
         quo_in = {quo_ff[DW-2:0], ge};
         cnt_in = cnt_ff - CNTW'(1);
         if (cnt_ff == CNTW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### rtl/gbc_dp.sv
// gbc_dp: datapath - sample registers, squaring units, sums, count, bias and result register.
// Uses gbc_pkg and instantiates gbc_div.
module gbc_dp #(
   parameter int ACCEL_ONE_G  = 4096,
   parameter int SAMPLE_WIDTH = 16,
   parameter int COUNT_WIDTH  = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  gbc_pkg::dp_cmd_type                    cmd,
   output gbc_pkg::dp_status_type                 status,
   input  logic [gbc_pkg::REQ_WIDTH-1:0]          required_samples,
   input  logic [gbc_pkg::ACC_TOL_WIDTH-1:0]      accel_tolerance,
   input  logic [gbc_pkg::GYRO_TOL_WIDTH-1:0]     gyro_tolerance,
   input  logic                                   in_command,
   input  logic                                   in_sample_valid,
   input  logic signed [SAMPLE_WIDTH-1:0]         in_accel_x,
   input  logic signed [SAMPLE_WIDTH-1:0]         in_accel_y,
   input  logic signed [SAMPLE_WIDTH-1:0]         in_accel_z,
   input  logic signed [SAMPLE_WIDTH-1:0]         in_rate_x,
   input  logic signed [SAMPLE_WIDTH-1:0]         in_rate_y,
   input  logic signed [SAMPLE_WIDTH-1:0]         in_rate_z,
   output logic                                   out_accepted,
   output logic                                   out_is_stationary,
   output logic                                   out_done_res,
   output logic [COUNT_WIDTH-1:0]                 out_samples_taken,
   output logic signed [SAMPLE_WIDTH-1:0]         out_corrected_x,
   output logic signed [SAMPLE_WIDTH-1:0]         out_corrected_y,
   output logic signed [SAMPLE_WIDTH-1:0]         out_corrected_z,
   output logic signed [gbc_pkg::BIAS_WIDTH-1:0]  out_offset_x,
   output logic signed [gbc_pkg::BIAS_WIDTH-1:0]  out_offset_y,
   output logic signed [gbc_pkg::BIAS_WIDTH-1:0]  out_offset_z
);

   localparam int SW    = SAMPLE_WIDTH;
   localparam int SQW   = 2 * SAMPLE_WIDTH;
   localparam int TSQW  = gbc_pkg::TOL_SQ_WIDTH;
   localparam int CMPW  = (SQW > TSQW) ? SQW : TSQW;
   localparam int BW    = gbc_pkg::BIAS_WIDTH;
   localparam int DIFW  = ((SW > BW) ? SW : BW) + 1;
   localparam int SUMW  = gbc_pkg::SUM_WIDTH;
   localparam int DW    = gbc_pkg::DIVIDEND_WIDTH;
   localparam int TOPW  = gbc_pkg::TOL_OP_WIDTH;

   localparam logic [TOPW-1:0]        ONE_G       = TOPW'(ACCEL_ONE_G);
   localparam logic [DW-1:0]          Q_POS_LIMIT = DW'(2 ** (BW - 1) - 1);
   localparam logic [DW-1:0]          Q_NEG_LIMIT = DW'(2 ** (BW - 1));
   localparam logic signed [SW-1:0]   SAT_MAX     = {1'b0, {(SW - 1){1'b1}}};
   localparam logic signed [SW-1:0]   SAT_MIN     = {1'b1, {(SW - 1){1'b0}}};

   function automatic logic [SW-1:0] mag_f(input logic signed [SW-1:0] v);
      logic [SW-1:0] u;
      u = v;
      return u[SW-1] ? (~u + SW'(1)) : u;
   endfunction

   function automatic logic signed [SW-1:0] sat_sub(input logic signed [SW-1:0] r,
                                                    input logic signed [BW-1:0] b);
      logic signed [DIFW-1:0] d;
      logic [DIFW-SW:0]       top;
      d   = DIFW'(r) - DIFW'(b);
      top = d[DIFW-1:SW-1];
      if ((&top) || !(|top)) begin
         return d[SW-1:0];
      end else if (d[DIFW-1]) begin
         return SAT_MIN;
      end else begin
         return SAT_MAX;
      end
   endfunction

   // sample registers
   logic                 cmd_ff, valid_ff;
   logic signed [SW-1:0] ax_ff, ay_ff, az_ff, rx_ff, ry_ff, rz_ff;

   always_ff @(posedge clock) begin
      if (cmd.in_load) begin
         cmd_ff   <= in_command;
         valid_ff <= in_sample_valid;
         ax_ff    <= in_accel_x;
         ay_ff    <= in_accel_y;
         az_ff    <= in_accel_z;
         rx_ff    <= in_rate_x;
         ry_ff    <= in_rate_y;
         rz_ff    <= in_rate_z;
      end
   end

   // squaring steps: one axis per cycle plus one tolerance bound
   logic signed [SW-1:0] acc_sel, rate_sel;
   logic [TOPW-1:0]      tol_op;
   logic [TOPW-1:0]      acc_tol_op;
   logic [SW-1:0]        acc_mag, rate_mag;
   logic [SQW-1:0]       acc_sq, rate_sq;
   logic [TSQW-1:0]      tol_sq;

   assign acc_tol_op = TOPW'(accel_tolerance);

   always_comb begin
      unique case (cmd.sq_axis)
         gbc_pkg::AXIS_X: begin
            acc_sel  = ax_ff;
            rate_sel = rx_ff;
            tol_op   = ONE_G + acc_tol_op;
         end
         gbc_pkg::AXIS_Y: begin
            acc_sel  = ay_ff;
            rate_sel = ry_ff;
            tol_op   = ONE_G - acc_tol_op;     // only used when one g exceeds the band
         end
         default: begin
            acc_sel  = az_ff;
            rate_sel = rz_ff;
            tol_op   = TOPW'(gyro_tolerance);
         end
      endcase
   end

   assign acc_mag  = mag_f(acc_sel);
   assign rate_mag = mag_f(rate_sel);
   assign acc_sq   = SQW'(acc_mag) * SQW'(acc_mag);
   assign rate_sq  = SQW'(rate_mag) * SQW'(rate_mag);
   assign tol_sq   = TSQW'(tol_op) * TSQW'(tol_op);

   logic [SQW-1:0]  a2_ff, g2_ff;
   logic [TSQW-1:0] up_ff, lo_ff, tg2_ff;
   logic            first_step;

   assign first_step = cmd.sq_axis == gbc_pkg::AXIS_X;

   always_ff @(posedge clock) begin
      if (cmd.sq_en) begin
         a2_ff <= (first_step ? '0 : a2_ff) + acc_sq;
         g2_ff <= (first_step ? '0 : g2_ff) + rate_sq;
         unique case (cmd.sq_axis)
            gbc_pkg::AXIS_X: up_ff  <= tol_sq;
            gbc_pkg::AXIS_Y: lo_ff  <= tol_sq;
            default:         tg2_ff <= tol_sq;
         endcase
      end
   end

   // stationarity test
   logic low_ok, stat_raw, stat_now, take;
   logic [COUNT_WIDTH-1:0] count_ff, count_inc;

   assign low_ok   = (ONE_G <= acc_tol_op) || (CMPW'(a2_ff) >= CMPW'(lo_ff));
   assign stat_raw = valid_ff && low_ok && (CMPW'(a2_ff) <= CMPW'(up_ff))
                     && (CMPW'(g2_ff) <= CMPW'(tg2_ff));
   assign stat_now = !cmd_ff && stat_raw;

   logic [SUMW-1:0]      sum_x_ff, sum_y_ff, sum_z_ff;
   logic signed [BW-1:0] bias_x_ff, bias_y_ff, bias_z_ff;
   logic                 cal_ff;
   logic                 acc_ff, stat_ff;

   assign count_inc       = count_ff + COUNT_WIDTH'(1);
   assign take            = stat_now && !cal_ff;
   assign status.complete = take && (gbc_pkg::REQ_WIDTH'(count_inc) >= required_samples);

   // rounded division of the selected sum
   logic [SUMW-1:0]        sum_sel, sum_mag;
   logic                   sum_neg;
   logic [COUNT_WIDTH-1:0] divisor;
   logic [DW-1:0]          dividend, quotient;
   logic                   div_done;
   logic signed [BW-1:0]   bias_res;

   always_comb begin
      unique case (cmd.div_axis)
         gbc_pkg::AXIS_X: sum_sel = sum_x_ff;
         gbc_pkg::AXIS_Y: sum_sel = sum_y_ff;
         default:         sum_sel = sum_z_ff;
      endcase
   end

   assign sum_neg  = sum_sel[SUMW-1];
   assign sum_mag  = sum_neg ? (~sum_sel + SUMW'(1)) : sum_sel;
   // a wrapped count of zero divides by one
   assign divisor  = (count_ff == '0) ? COUNT_WIDTH'(1) : count_ff;
   assign dividend = DW'(sum_mag) + DW'(divisor >> 1);

   gbc_div #(
      .DIVISOR_WIDTH(COUNT_WIDTH)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .dividend(dividend),
      .divisor (divisor),
      .done    (div_done),
      .quotient(quotient)
   );

   assign status.div_done = div_done;

   always_comb begin
      if (!sum_neg) begin
         bias_res = (quotient > Q_POS_LIMIT) ? gbc_pkg::BIAS_MAX : quotient[BW-1:0];
      end else begin
         bias_res = (quotient > Q_NEG_LIMIT) ? gbc_pkg::BIAS_MIN
                                             : BW'(BW'(0) - quotient[BW-1:0]);
      end
   end

   // calibration state
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_x_ff  <= '0;
         sum_y_ff  <= '0;
         sum_z_ff  <= '0;
         count_ff  <= '0;
         bias_x_ff <= '0;
         bias_y_ff <= '0;
         bias_z_ff <= '0;
         cal_ff    <= 1'b0;
      end else begin
         if (cmd.eval) begin
            if (cmd_ff) begin
               sum_x_ff  <= '0;
               sum_y_ff  <= '0;
               sum_z_ff  <= '0;
               count_ff  <= '0;
               bias_x_ff <= '0;
               bias_y_ff <= '0;
               bias_z_ff <= '0;
               cal_ff    <= 1'b0;
            end else if (take) begin
               sum_x_ff <= sum_x_ff + SUMW'(rx_ff);
               sum_y_ff <= sum_y_ff + SUMW'(ry_ff);
               sum_z_ff <= sum_z_ff + SUMW'(rz_ff);
               count_ff <= count_inc;
            end
         end
         if (cmd.bias_load) begin
            unique case (cmd.div_axis)
               gbc_pkg::AXIS_X: bias_x_ff <= bias_res;
               gbc_pkg::AXIS_Y: bias_y_ff <= bias_res;
               default:         bias_z_ff <= bias_res;
            endcase
         end
         if (cmd.set_cal) begin
            cal_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         acc_ff  <= !cmd_ff && (cal_ff || stat_raw);
         stat_ff <= stat_now;
      end
   end

   // result register
   logic                 o_acc_ff, o_stat_ff, o_done_ff;
   logic [COUNT_WIDTH-1:0] o_count_ff;
   logic signed [SW-1:0] o_cx_ff, o_cy_ff, o_cz_ff;
   logic signed [BW-1:0] o_bx_ff, o_by_ff, o_bz_ff;

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         o_acc_ff   <= acc_ff;
         o_stat_ff  <= stat_ff;
         o_done_ff  <= cal_ff;
         o_count_ff <= count_ff;
         o_cx_ff    <= cal_ff ? sat_sub(rx_ff, bias_x_ff) : rx_ff;
         o_cy_ff    <= cal_ff ? sat_sub(ry_ff, bias_y_ff) : ry_ff;
         o_cz_ff    <= cal_ff ? sat_sub(rz_ff, bias_z_ff) : rz_ff;
         o_bx_ff    <= cal_ff ? bias_x_ff : '0;
         o_by_ff    <= cal_ff ? bias_y_ff : '0;
         o_bz_ff    <= cal_ff ? bias_z_ff : '0;
      end
   end

   assign out_accepted      = o_acc_ff;
   assign out_is_stationary = o_stat_ff;
   assign out_done_res      = o_done_ff;
   assign out_samples_taken = o_count_ff;
   assign out_corrected_x   = o_cx_ff;
   assign out_corrected_y   = o_cy_ff;
   assign out_corrected_z   = o_cz_ff;
   assign out_offset_x      = o_bx_ff;
   assign out_offset_y      = o_by_ff;
   assign out_offset_z      = o_bz_ff;

endmodule

### rtl/gbc_ctrl.sv
// gbc_ctrl: sequencing state machine and result-valid flag.
// Uses gbc_pkg for the state, axis, command and status types.
module gbc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  gbc_pkg::dp_status_type status,
   output gbc_pkg::dp_cmd_type    cmd
);

   gbc_pkg::state_type state_ff, state_in;
   gbc_pkg::axis_type  axis_ff, axis_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free, accept;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == gbc_pkg::ST_IDLE)
                        || ((state_ff == gbc_pkg::ST_RESULT) && out_free));
   assign accept    = req_valid && !req_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      unique case (state_ff)
         gbc_pkg::ST_IDLE: begin
            if (accept) state_in = gbc_pkg::ST_SQ0;
         end
         gbc_pkg::ST_SQ0: state_in = gbc_pkg::ST_SQ1;
         gbc_pkg::ST_SQ1: state_in = gbc_pkg::ST_SQ2;
         gbc_pkg::ST_SQ2: state_in = gbc_pkg::ST_EVAL;
         gbc_pkg::ST_EVAL: begin
            axis_in  = gbc_pkg::AXIS_X;
            state_in = status.complete ? gbc_pkg::ST_DIV_START : gbc_pkg::ST_RESULT;
         end
         gbc_pkg::ST_DIV_START: state_in = gbc_pkg::ST_DIV_WAIT;
         gbc_pkg::ST_DIV_WAIT: begin
            if (status.div_done) begin
               unique case (axis_ff)
                  gbc_pkg::AXIS_X: begin
                     axis_in  = gbc_pkg::AXIS_Y;
                     state_in = gbc_pkg::ST_DIV_START;
                  end
                  gbc_pkg::AXIS_Y: begin
                     axis_in  = gbc_pkg::AXIS_Z;
                     state_in = gbc_pkg::ST_DIV_START;
                  end
                  default: state_in = gbc_pkg::ST_RESULT;
               endcase
            end
         end
         gbc_pkg::ST_RESULT: begin
            if (out_free) state_in = accept ? gbc_pkg::ST_SQ0 : gbc_pkg::ST_IDLE;
         end
         default: state_in = gbc_pkg::ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd          = '0;
      cmd.in_load  = accept;
      cmd.div_axis = axis_ff;
      unique case (state_ff)
         gbc_pkg::ST_SQ0: begin
            cmd.sq_en   = 1'b1;
            cmd.sq_axis = gbc_pkg::AXIS_X;
         end
         gbc_pkg::ST_SQ1: begin
            cmd.sq_en   = 1'b1;
            cmd.sq_axis = gbc_pkg::AXIS_Y;
         end
         gbc_pkg::ST_SQ2: begin
            cmd.sq_en   = 1'b1;
            cmd.sq_axis = gbc_pkg::AXIS_Z;
         end
         gbc_pkg::ST_EVAL:      cmd.eval      = 1'b1;
         gbc_pkg::ST_DIV_START: cmd.div_start = 1'b1;
         gbc_pkg::ST_DIV_WAIT: begin
            cmd.bias_load = status.div_done;
            cmd.set_cal   = status.div_done && (axis_ff == gbc_pkg::AXIS_Z);
         end
         gbc_pkg::ST_RESULT:    cmd.out_load  = out_free;
         default: ;
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gbc_pkg::ST_IDLE;
         axis_ff      <= gbc_pkg::AXIS_X;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### rtl/gyro_bias_calibrator_core.sv
// gyro_bias_calibrator_core: top level - configuration registers, controller and datapath.
// Uses gbc_pkg; instantiates gbc_ctrl and gbc_dp (which holds gbc_div).
//
// Gyro bias calibrator. Each req_ transaction carries one IMU sample or a restart
// command and yields exactly one rsp_ transaction. A sample normally passes through
// ST_SQ0, ST_SQ1 and ST_SQ2, in which one shared squaring step per stream (accel, gyro,
// tolerance bound) handles one axis each, ST_EVAL for the stationarity test and state
// update, and ST_RESULT, which loads the result register and in which the next sample
// is already taken. The sample that completes the calibration also runs three rounded
// divisions through one restoring divider, 33 quotient bits at one per cycle, one axis
// after the other. While a result waits on rsp_stall the block still takes the next
// sample and works it up to the result stage. Registers are written over csr_ (always
// ready): index 0 required sample count, 1 accel tolerance, 2 gyro tolerance; other
// indices are dropped. Write them only while idle.
module gyro_bias_calibrator_core #(
   parameter int ACCEL_ONE_G  = 4096,
   parameter int SAMPLE_WIDTH = 16,
   parameter int COUNT_WIDTH  = 16
) (
   input  logic                                       clock,
   input  logic                                       reset,
   // sample channel
   input  logic                                       req_valid,
   output logic                                       req_stall,
   input  logic                                       req_command,
   input  logic                                       req_sample_valid,
   input  logic signed [SAMPLE_WIDTH-1:0]             req_accel_x,
   input  logic signed [SAMPLE_WIDTH-1:0]             req_accel_y,
   input  logic signed [SAMPLE_WIDTH-1:0]             req_accel_z,
   input  logic signed [SAMPLE_WIDTH-1:0]             req_rate_x,
   input  logic signed [SAMPLE_WIDTH-1:0]             req_rate_y,
   input  logic signed [SAMPLE_WIDTH-1:0]             req_rate_z,
   // result channel
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output logic                                       rsp_accepted,
   output logic                                       rsp_is_stationary,
   output logic                                       rsp_done_res,
   output logic [COUNT_WIDTH-1:0]                     rsp_samples_taken,
   output logic signed [SAMPLE_WIDTH-1:0]             rsp_corrected_x,
   output logic signed [SAMPLE_WIDTH-1:0]             rsp_corrected_y,
   output logic signed [SAMPLE_WIDTH-1:0]             rsp_corrected_z,
   output logic signed [gbc_pkg::BIAS_WIDTH-1:0]      rsp_offset_x,
   output logic signed [gbc_pkg::BIAS_WIDTH-1:0]      rsp_offset_y,
   output logic signed [gbc_pkg::BIAS_WIDTH-1:0]      rsp_offset_z,
   // register write channel
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic [gbc_pkg::CSR_INDEX_WIDTH-1:0]        csr_index,
   input  logic [gbc_pkg::CSR_DATA_WIDTH-1:0]         csr_wdata
);

   // configuration registers; upper data bits beyond a register's width are dropped
   logic [gbc_pkg::REQ_WIDTH-1:0]      req_samples_ff;
   logic [gbc_pkg::ACC_TOL_WIDTH-1:0]  accel_tol_ff;
   logic [gbc_pkg::GYRO_TOL_WIDTH-1:0] gyro_tol_ff;
   logic                               csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_samples_ff <= gbc_pkg::REQUIRED_RESET;
         accel_tol_ff   <= gbc_pkg::ACC_TOL_RESET;
         gyro_tol_ff    <= gbc_pkg::GYRO_TOL_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            gbc_pkg::CSR_REQUIRED_SAMPLES:
               req_samples_ff <= csr_wdata[gbc_pkg::REQ_WIDTH-1:0];
            gbc_pkg::CSR_ACCEL_TOLERANCE:
               accel_tol_ff <= csr_wdata[gbc_pkg::ACC_TOL_WIDTH-1:0];
            gbc_pkg::CSR_GYRO_TOLERANCE:
               gyro_tol_ff <= csr_wdata[gbc_pkg::GYRO_TOL_WIDTH-1:0];
            default: ;   // unknown index: ignored
         endcase
      end
   end

   gbc_pkg::dp_cmd_type    cmd;
   gbc_pkg::dp_status_type status;

   gbc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .status   (status),
      .cmd      (cmd)
   );

   gbc_dp #(
      .ACCEL_ONE_G (ACCEL_ONE_G),
      .SAMPLE_WIDTH(SAMPLE_WIDTH),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .required_samples (req_samples_ff),
      .accel_tolerance  (accel_tol_ff),
      .gyro_tolerance   (gyro_tol_ff),
      .in_command       (req_command),
      .in_sample_valid  (req_sample_valid),
      .in_accel_x       (req_accel_x),
      .in_accel_y       (req_accel_y),
      .in_accel_z       (req_accel_z),
      .in_rate_x        (req_rate_x),
      .in_rate_y        (req_rate_y),
      .in_rate_z        (req_rate_z),
      .out_accepted     (rsp_accepted),
      .out_is_stationary(rsp_is_stationary),
      .out_done_res     (rsp_done_res),
      .out_samples_taken(rsp_samples_taken),
      .out_corrected_x  (rsp_corrected_x),
      .out_corrected_y  (rsp_corrected_y),
      .out_corrected_z  (rsp_corrected_z),
      .out_offset_x     (rsp_offset_x),
      .out_offset_y     (rsp_offset_y),
      .out_offset_z     (rsp_offset_z)
   );

endmodule

### rtl/gbc_checker.sv
// gbc_port_checker: port-level assertions for gyro_bias_calibrator_core, with its bind.
// Uses gbc_pkg for the fixed widths.
module gbc_port_checker #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int COUNT_WIDTH  = 16
) (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_stall,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic                                  rsp_accepted,
   input logic                                  rsp_done_res,
   input logic [COUNT_WIDTH-1:0]                rsp_samples_taken,
   input logic signed [SAMPLE_WIDTH-1:0]        rsp_corrected_x,
   input logic signed [gbc_pkg::BIAS_WIDTH-1:0] rsp_offset_x,
   input logic signed [gbc_pkg::BIAS_WIDTH-1:0] rsp_offset_y,
   input logic signed [gbc_pkg::BIAS_WIDTH-1:0] rsp_offset_z
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_samples_taken)
         && $stable(rsp_corrected_x) && $stable(rsp_offset_x))
      else $error("stalled result changed");

   // one sample at a time: a taken sample blocks the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("sample taken while previous one in flight");

   a_offset_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_done_res |->
         rsp_offset_x == '0 && rsp_offset_y == '0 && rsp_offset_z == '0)
      else $error("offset reported before calibration done");

   a_done_accepts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> rsp_accepted)
      else $error("calibrated result not accepted");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind gyro_bias_calibrator_core gbc_port_checker #(
   .SAMPLE_WIDTH(SAMPLE_WIDTH),
   .COUNT_WIDTH (COUNT_WIDTH)
) u_gbc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_accepted     (rsp_accepted),
   .rsp_done_res     (rsp_done_res),
   .rsp_samples_taken(rsp_samples_taken),
   .rsp_corrected_x  (rsp_corrected_x),
   .rsp_offset_x     (rsp_offset_x),
   .rsp_offset_y     (rsp_offset_y),
   .rsp_offset_z     (rsp_offset_z)
);

### tb/gbc_checker.sv
// gbc_checker: watches the sample, result and register channels of the calibrator,
// predicts each result transaction and compares it field by field with the block.
// Depends on gbc_pkg for register indices, widths and register reset values.
module gbc_checker #(
   parameter int ACCEL_ONE_G = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic                                req_command,
   input  logic                                req_sample_valid,
   input  logic signed [15:0]                  req_accel_x,
   input  logic signed [15:0]                  req_accel_y,
   input  logic signed [15:0]                  req_accel_z,
   input  logic signed [15:0]                  req_rate_x,
   input  logic signed [15:0]                  req_rate_y,
   input  logic signed [15:0]                  req_rate_z,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic                                rsp_accepted,
   input  logic                                rsp_is_stationary,
   input  logic                                rsp_done_res,
   input  logic [15:0]                         rsp_samples_taken,
   input  logic signed [15:0]                  rsp_corrected_x,
   input  logic signed [15:0]                  rsp_corrected_y,
   input  logic signed [15:0]                  rsp_corrected_z,
   input  logic signed [15:0]                  rsp_offset_x,
   input  logic signed [15:0]                  rsp_offset_y,
   input  logic signed [15:0]                  rsp_offset_z,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [gbc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [gbc_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output int                                  fail_count,
   output int                                  owed_count,
   output int                                  checked_count,
   output int                                  calib_count
);

   typedef struct {
      logic               accepted;
      logic               is_stationary;
      logic               done_res;
      logic [15:0]        samples_taken;
      logic signed [15:0] corrected_x;
      logic signed [15:0] corrected_y;
      logic signed [15:0] corrected_z;
      logic signed [15:0] offset_x;
      logic signed [15:0] offset_y;
      logic signed [15:0] offset_z;
   } imu_result_type;

   // register copies
   logic [gbc_pkg::REQ_WIDTH-1:0]      need_count;
   logic [gbc_pkg::ACC_TOL_WIDTH-1:0]  accel_tol;
   logic [gbc_pkg::GYRO_TOL_WIDTH-1:0] gyro_tol;

   // calibration state
   logic [gbc_pkg::SUM_WIDTH-1:0]         rate_sum [3];
   logic [15:0]                           still_count;
   logic signed [gbc_pkg::BIAS_WIDTH-1:0] bias_est [3];
   logic                                  frozen;

   imu_result_type calib_results_q [$];

   function automatic logic signed [15:0] clamp16(input longint v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   // rounded to nearest, ties away from zero
   function automatic longint nearest_quotient(input longint s, input longint n);
      longint mag;
      longint q;
      mag = (s < 0) ? -s : s;
      q = (mag + n / 2) / n;
      return (s < 0) ? -q : q;
   endfunction

   function automatic imu_result_type calibrate_step(
         input logic cmd, input logic valid_in,
         input logic signed [15:0] ax, input logic signed [15:0] ay,
         input logic signed [15:0] az, input logic signed [15:0] gx,
         input logic signed [15:0] gy, input logic signed [15:0] gz);
      imu_result_type r;
      longint rate [3];
      longint a2, g2, one_g, ta, tg, div_n;
      int signed sum_s;
      logic stat, take;
      int i;
      rate[0] = longint'(gx);
      rate[1] = longint'(gy);
      rate[2] = longint'(gz);
      stat = 1'b0;
      take = 1'b0;
      r.corrected_x = gx;
      r.corrected_y = gy;
      r.corrected_z = gz;
      if (cmd) begin
         for (i = 0; i < 3; i++) begin
            rate_sum[i] = '0;
            bias_est[i] = '0;
         end
         still_count = '0;
         frozen = 1'b0;
      end else begin
         if (valid_in) begin
            a2 = longint'(ax) * longint'(ax) + longint'(ay) * longint'(ay)
                 + longint'(az) * longint'(az);
            g2 = rate[0] * rate[0] + rate[1] * rate[1] + rate[2] * rate[2];
            one_g = longint'(ACCEL_ONE_G);
            ta = longint'(accel_tol);
            tg = longint'(gyro_tol);
            // squared bounds; lower bound vanishes once the band reaches zero g
            stat = (a2 <= (one_g + ta) * (one_g + ta)) &&
                   (one_g <= ta || a2 >= (one_g - ta) * (one_g - ta)) &&
                   (g2 <= tg * tg);
         end
         if (frozen) begin
            take = 1'b1;
         end else if (stat) begin
            take = 1'b1;
            for (i = 0; i < 3; i++) rate_sum[i] = rate_sum[i] + rate[i][31:0];
            still_count = still_count + 16'd1;
            if (still_count >= need_count) begin
               div_n = (still_count == '0) ? longint'(1) : longint'(still_count);
               for (i = 0; i < 3; i++) begin
                  sum_s = rate_sum[i];
                  bias_est[i] = clamp16(nearest_quotient(longint'(sum_s), div_n));
               end
               frozen = 1'b1;
               calib_count = calib_count + 1;
            end
         end
         if (frozen) begin
            r.corrected_x = clamp16(rate[0] - longint'(bias_est[0]));
            r.corrected_y = clamp16(rate[1] - longint'(bias_est[1]));
            r.corrected_z = clamp16(rate[2] - longint'(bias_est[2]));
         end
      end
      r.accepted      = take;
      r.is_stationary = stat;
      r.done_res      = frozen;
      r.samples_taken = still_count;
      r.offset_x      = frozen ? bias_est[0] : 16'sd0;
      r.offset_y      = frozen ? bias_est[1] : 16'sd0;
      r.offset_z      = frozen ? bias_est[2] : 16'sd0;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         fail_count = fail_count + 1;
      end
   endtask

   always @(posedge clock) begin
      imu_result_type want;
      if (reset) begin
         need_count  = gbc_pkg::REQUIRED_RESET;
         accel_tol   = gbc_pkg::ACC_TOL_RESET;
         gyro_tol    = gbc_pkg::GYRO_TOL_RESET;
         for (int i = 0; i < 3; i++) begin
            rate_sum[i] = '0;
            bias_est[i] = '0;
         end
         still_count = '0;
         frozen      = 1'b0;
         calib_results_q.delete();
      end else begin
         // result first: it belongs to an older sample than any taken at this edge
         if (rsp_valid && !rsp_stall) begin
            if (calib_results_q.size() == 0) begin
               $display("%0t: result transaction with no prediction waiting", $time);
               fail_count = fail_count + 1;
            end else begin
               want = calib_results_q.pop_front();
               check_field("accepted",      16'(want.accepted),      16'(rsp_accepted));
               check_field("is_stationary", 16'(want.is_stationary),
                           16'(rsp_is_stationary));
               check_field("done_res",      16'(want.done_res),      16'(rsp_done_res));
               check_field("samples_taken", want.samples_taken, rsp_samples_taken);
               check_field("corrected_x",   want.corrected_x,   rsp_corrected_x);
               check_field("corrected_y",   want.corrected_y,   rsp_corrected_y);
               check_field("corrected_z",   want.corrected_z,   rsp_corrected_z);
               check_field("offset_x",      want.offset_x,      rsp_offset_x);
               check_field("offset_y",      want.offset_y,      rsp_offset_y);
               check_field("offset_z",      want.offset_z,      rsp_offset_z);
               checked_count = checked_count + 1;
            end
         end
         if (req_valid && !req_stall)
            calib_results_q.push_back(calibrate_step(req_command, req_sample_valid,
                  req_accel_x, req_accel_y, req_accel_z,
                  req_rate_x, req_rate_y, req_rate_z));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               gbc_pkg::CSR_REQUIRED_SAMPLES: need_count = csr_wdata;
               gbc_pkg::CSR_ACCEL_TOLERANCE:
                  accel_tol = csr_wdata[gbc_pkg::ACC_TOL_WIDTH-1:0];
               gbc_pkg::CSR_GYRO_TOLERANCE:
                  gyro_tol  = csr_wdata[gbc_pkg::GYRO_TOL_WIDTH-1:0];
               default: ;
            endcase
         end
      end
      owed_count = calib_results_q.size();
   end

endmodule

### tb/gyro_bias_calibrator_core_tb.sv
// gyro_bias_calibrator_core_tb: clock, reset and stimulus for the gyro bias calibrator.
// Depends on gbc_pkg, gyro_bias_calibrator_core and gbc_checker (which predicts and checks).
module gyro_bias_calibrator_core_tb;

   localparam int ACCEL_ONE_G     = 4096;
   localparam int PHASES          = 14;
   localparam int PHASE_ITEMS     = 38;
   localparam int HOLD_OFF_CYCLES = 300;   // long receiver hold-off, fills the block
   // the completing sample runs three divisions; leave margin
   localparam int SETTLE_CYCLES   = 20;
   localparam int RUN_LIMIT       = 5_000_000;
   // index 3 is not decoded by the block; writes to it must be dropped
   localparam logic [gbc_pkg::CSR_INDEX_WIDTH-1:0] CSR_SPARE_INDEX = 2'd3;

   typedef struct {
      logic               cmd;
      logic               sample_valid;
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic signed [15:0] rate_x;
      logic signed [15:0] rate_y;
      logic signed [15:0] rate_z;
   } imu_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid        = 1'b0;
   logic               req_stall;
   logic               req_command      = 1'b0;
   logic               req_sample_valid = 1'b0;
   logic signed [15:0] req_accel_x      = '0;
   logic signed [15:0] req_accel_y      = '0;
   logic signed [15:0] req_accel_z      = '0;
   logic signed [15:0] req_rate_x       = '0;
   logic signed [15:0] req_rate_y       = '0;
   logic signed [15:0] req_rate_z       = '0;

   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_accepted;
   logic               rsp_is_stationary;
   logic               rsp_done_res;
   logic [15:0]        rsp_samples_taken;
   logic signed [15:0] rsp_corrected_x;
   logic signed [15:0] rsp_corrected_y;
   logic signed [15:0] rsp_corrected_z;
   logic signed [15:0] rsp_offset_x;
   logic signed [15:0] rsp_offset_y;
   logic signed [15:0] rsp_offset_z;

   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [gbc_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [gbc_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   int fail_count;
   int owed_count;
   int checked_count;
   int calib_count;

   // shared between stimulus and the result-side process
   logic throttle_on      = 1'b1;   // random idling on both channels
   logic hold_off_pending = 1'b0;   // receiver to hold off for HOLD_OFF_CYCLES

   // mirror of the register contents, used to shape stationary samples
   int cur_acc_tol  = int'(gbc_pkg::ACC_TOL_RESET);
   int cur_gyro_tol = int'(gbc_pkg::GYRO_TOL_RESET);
   int drift_x, drift_y, drift_z;   // per-phase gyro offset the block should find
   int items_sent = 0;
   int settings_done = 0;

   always #5 clock = ~clock;

   gyro_bias_calibrator_core #(
      .ACCEL_ONE_G (ACCEL_ONE_G),
      .SAMPLE_WIDTH(16),
      .COUNT_WIDTH (16)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_sample_valid (req_sample_valid),
      .req_accel_x      (req_accel_x),
      .req_accel_y      (req_accel_y),
      .req_accel_z      (req_accel_z),
      .req_rate_x       (req_rate_x),
      .req_rate_y       (req_rate_y),
      .req_rate_z       (req_rate_z),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_accepted     (rsp_accepted),
      .rsp_is_stationary(rsp_is_stationary),
      .rsp_done_res     (rsp_done_res),
      .rsp_samples_taken(rsp_samples_taken),
      .rsp_corrected_x  (rsp_corrected_x),
      .rsp_corrected_y  (rsp_corrected_y),
      .rsp_corrected_z  (rsp_corrected_z),
      .rsp_offset_x     (rsp_offset_x),
      .rsp_offset_y     (rsp_offset_y),
      .rsp_offset_z     (rsp_offset_z),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   gbc_checker #(
      .ACCEL_ONE_G(ACCEL_ONE_G)
   ) i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_sample_valid (req_sample_valid),
      .req_accel_x      (req_accel_x),
      .req_accel_y      (req_accel_y),
      .req_accel_z      (req_accel_z),
      .req_rate_x       (req_rate_x),
      .req_rate_y       (req_rate_y),
      .req_rate_z       (req_rate_z),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_accepted     (rsp_accepted),
      .rsp_is_stationary(rsp_is_stationary),
      .rsp_done_res     (rsp_done_res),
      .rsp_samples_taken(rsp_samples_taken),
      .rsp_corrected_x  (rsp_corrected_x),
      .rsp_corrected_y  (rsp_corrected_y),
      .rsp_corrected_z  (rsp_corrected_z),
      .rsp_offset_x     (rsp_offset_x),
      .rsp_offset_y     (rsp_offset_y),
      .rsp_offset_z     (rsp_offset_z),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .fail_count       (fail_count),
      .owed_count       (owed_count),
      .checked_count    (checked_count),
      .calib_count      (calib_count)
   );

   // Idle length: mostly short, now and then a long one. Never zero.
   function automatic int idle_len();
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic int spread(input int half);
      return int'($urandom_range(0, 2 * half)) - half;
   endfunction

   function automatic imu_item_type mk(input logic cmd, input logic sv,
         input int ax, input int ay, input int az,
         input int gx, input int gy, input int gz);
      imu_item_type it;
      it.cmd = cmd;
      it.sample_valid = sv;
      it.accel_x = ax[15:0];
      it.accel_y = ay[15:0];
      it.accel_z = az[15:0];
      it.rate_x  = gx[15:0];
      it.rate_y  = gy[15:0];
      it.rate_z  = gz[15:0];
      return it;
   endfunction

   // Fully random bits; now and then a restart among them.
   function automatic imu_item_type noise_item();
      return mk($urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)),
                $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
   endfunction

   // A sample that should pass the stationarity test, or land near its edges:
   // one axis carries about one g, the others a little jitter; gyro sits
   // around the phase drift.
   function automatic imu_item_type calm_item();
      int a [3];
      int g [3];
      int main_g, axis, jit, tg;
      tg = cur_gyro_tol;
      main_g = ACCEL_ONE_G + spread(cur_acc_tol);
      if (main_g > 32767) main_g = 32767;
      if ($urandom_range(0, 1)) main_g = -main_g;
      jit = $urandom_range(0, 1) ? 30 : 0;
      for (int i = 0; i < 3; i++) a[i] = spread(jit);
      axis = $urandom_range(0, 2);
      a[axis] = main_g;
      if ($urandom_range(0, 9) == 0) begin
         // gyro magnitude right on the limit
         g[0] = 0;
         g[1] = 0;
         g[2] = 0;
         axis = $urandom_range(0, 2);
         g[axis] = $urandom_range(0, 1) ? tg : -tg;
      end else begin
         g[0] = drift_x + spread(tg / 4);
         g[1] = drift_y + spread(tg / 4);
         g[2] = drift_z + spread(tg / 4);
      end
      return mk(1'b0, 1'b1, a[0], a[1], a[2], g[0], g[1], g[2]);
   endfunction

   // Offer one sample transaction (called at a falling edge) and wait for it to go in.
   task automatic send(input imu_item_type it);
      req_valid        <= 1'b1;
      req_command      <= it.cmd;
      req_sample_valid <= it.sample_valid;
      req_accel_x      <= it.accel_x;
      req_accel_y      <= it.accel_y;
      req_accel_z      <= it.accel_z;
      req_rate_x       <= it.rate_x;
      req_rate_y       <= it.rate_y;
      req_rate_z       <= it.rate_z;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      @(negedge clock);
      if (throttle_on && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         repeat (idle_len()) @(negedge clock);
      end
   endtask

   task automatic write_reg(input logic [gbc_pkg::CSR_INDEX_WIDTH-1:0] index,
                            input logic [gbc_pkg::CSR_DATA_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_config(input logic [15:0] need, input logic [15:0] acc_tol,
                             input logic [15:0] gyro_tol);
      write_reg(gbc_pkg::CSR_REQUIRED_SAMPLES, need);
      write_reg(gbc_pkg::CSR_ACCEL_TOLERANCE, acc_tol);
      write_reg(gbc_pkg::CSR_GYRO_TOLERANCE, gyro_tol);
      // top bit of each tolerance is dropped by the block
      cur_acc_tol  = int'(acc_tol & 16'h7FFF);
      cur_gyro_tol = int'(gyro_tol & 16'h7FFF);
      settings_done++;
   endtask

   // Stop offering, let every owed result drain, then give the divider time to go quiet.
   task automatic finish_batch();
      req_valid <= 1'b0;
      while (owed_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Result side: random stall runs, plus one long hold-off on request.
   initial begin : result_side
      forever begin
         @(negedge clock);
         if (hold_off_pending) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_pending = 1'b0;
            rsp_stall <= 1'b0;
         end else if (throttle_on && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat (idle_len()) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : stimulus
      int r;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // ---- directed part, reset register values (1000 / 410 / 100) ----
      send(mk(1'b1, 1'b1, -32768, -32768, -32768, -32768, -32768, -32768));  // restart
      send(mk(1'b0, 1'b0, 0, 0, 4096, 0, 0, 0));    // invalid flag, never stationary
      send(mk(1'b0, 1'b1, 0, 0, 4506, 100, 0, 0));  // accel and gyro exactly on upper edge
      send(mk(1'b0, 1'b1, 0, 0, 4507, 0, 0, 0));    // one unit over the accel band
      send(mk(1'b0, 1'b1, 0, -3686, 0, 0, -5, 3));  // exactly on the lower accel edge
      send(mk(1'b0, 1'b1, 3685, 0, 0, 0, 0, 0));    // one unit under it
      send(mk(1'b0, 1'b1, 0, 0, 4096, 0, 0, 101));  // gyro one unit over
      send(mk(1'b0, 1'b1, 32767, 32767, 32767, 32767, 32767, 32767));
      send(mk(1'b0, 1'b1, -32768, -32768, -32768, -32768, -32768, -32768));
      finish_batch();

      // zero required count, accel band of one g (no lower bound), zero gyro band
      set_config(16'd0, 16'd4096, 16'd0);
      send(mk(1'b0, 1'b1, 0, 0, 0, 0, 0, 0));       // completes on the sums so far
      send(mk(1'b0, 1'b1, 100, -200, 300, 12345, -32768, 32767));   // already calibrated
      send(mk(1'b1, 1'b0, 0, 0, 0, 0, 0, 0));
      finish_batch();

      // unknown index is dropped; tolerance writes carry a top bit that is ignored
      write_reg(CSR_SPARE_INDEX, 16'h0005);
      set_config(16'd1, 16'hFFFF, 16'hFFFF);
      send(mk(1'b0, 1'b1, 0, 0, 0, 32767, 0, 0));   // bias x at full positive scale
      send(mk(1'b0, 1'b1, 5, 5, 5, -32768, -32768, 0));  // corrected x saturates low
      send(mk(1'b1, 1'b0, 0, 0, 0, 0, 0, 0));
      send(mk(1'b0, 1'b1, 0, 0, 0, -32767, 0, 0));  // bias x at full negative scale
      send(mk(1'b0, 1'b1, 0, 0, 0, 32767, 32767, -32768));   // corrected x saturates high
      finish_batch();

      // ---- random phases: one register setting each, idle between them ----
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       set_config(16'd3, 16'd410, 16'd100);
            1:       set_config(16'd1, 16'd0, 16'd100);       // exact one g only
            2:       set_config(16'd8, 16'd200, 16'd0);       // gyro must be all zero
            3: begin
               write_reg(CSR_SPARE_INDEX, 16'($urandom));
               set_config(16'hFFFF, 16'd410, 16'd300);       // never completes
            end
            4:       set_config(16'd5, 16'd16384, 16'd500);
            5:       set_config(16'd0, 16'd300, 16'h7FFF);
            default: set_config(16'($urandom_range(1, 12)), 16'($urandom_range(0, 2000)),
                                16'($urandom_range(0, 2000)));
         endcase
         drift_x = spread(cur_gyro_tol / 3);
         drift_y = spread(cur_gyro_tol / 3);
         drift_z = spread(cur_gyro_tol / 3);
         // phases 1 and 7 run flat out on both channels
         throttle_on = (p != 1 && p != 7);
         if (p == 6) hold_off_pending = 1'b1;

         send(mk(1'b1, 1'b0, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            r = $urandom_range(0, 99);
            if (r < 72) begin
               send(calm_item());
            end else if (r < 82) begin
               imu_item_type it;
               it = calm_item();
               it.sample_valid = 1'b0;
               send(it);
            end else if (r < 95) begin
               send(noise_item());
            end else begin
               send(mk(1'b1, 1'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom));
            end
         end
         finish_batch();
      end

      $display("Covered %0d sample transactions under %0d register settings:",
               items_sent, settings_done);
      $display("  %0d results compared, %0d calibrations completed.",
               checked_count, calib_count);
      if (fail_count == 0 && owed_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin : watchdog
      #(RUN_LIMIT);
      $display("%0t: run did not finish in time, %0d results still owed",
               $time, owed_count);
      $display("TEST FAILED");
      $finish;
   end

endmodule
